[rtl/bfd_pkg.sv]
package bfd_pkg;

   // Fixed field widths
   localparam int PIX_W       = 8;
   localparam int SUM_W       = 18;
   localparam int COORD_W     = 7;
   localparam int ROW_W       = 8;
   localparam int SRC_W       = 13;
   localparam int SRC_CNT_W   = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [SRC_W-1:0] MAX_SRC_WIDTH  = 13'd4096;
   localparam logic [ROW_W-1:0] MAX_OUT_HEIGHT = 8'd128;
   localparam logic [PIX_W-1:0] PIX_MAX        = 8'd255;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_W    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_H    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ALPHA  = 3'd5;

   // Register reset values
   localparam logic [SRC_W-1:0] RST_SRC_WIDTH  = 13'd128;
   localparam logic [7:0]       RST_OUT_WIDTH  = 8'd64;
   localparam logic [7:0]       RST_OUT_HEIGHT = 8'd64;
   localparam logic [5:0]       RST_SCALE_W    = 6'd2;
   localparam logic [5:0]       RST_SCALE_H    = 6'd2;
   localparam logic             RST_HAS_ALPHA  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

[rtl/bfd_ram.sv]
module bfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bfd_divider.sv]
module bfd_divider
   import bfd_pkg::*;
#(
   parameter int LANES = 4,
   parameter int DIV_W = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [LANES-1:0][SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0]            divisor,
   output logic                        done,
   output logic [LANES-1:0][SUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W);

   logic                        busy_ff, busy_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [DIV_W-1:0]            dsr_ff, dsr_in;
   logic [LANES-1:0][SUM_W-1:0] quo_ff, quo_in;
   logic [LANES-1:0][DIV_W-1:0] rem_ff, rem_in;

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

   // One restoring step per cycle, all lanes side by side
   always_comb begin
      logic [DIV_W:0] shifted;
      logic [DIV_W:0] diff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      shifted = '0;
      diff    = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W - 1);
         dsr_in  = divisor;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int l = 0; l < LANES; l++) begin
            shifted = {rem_ff[l], quo_ff[l][SUM_W-1]};
            diff    = shifted - {1'b0, dsr_ff};
            if (shifted >= {1'b0, dsr_ff}) begin
               rem_in[l] = diff[DIV_W-1:0];
               quo_in[l] = {quo_ff[l][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[l] = shifted[DIV_W-1:0];
               quo_in[l] = {quo_ff[l][SUM_W-2:0], 1'b0};
            end
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

[rtl/box_filter_downscaler_top.sv]
// A pixel outside the active area only moves the position; an active pixel has a memory read, then a write.
// A pixel that completes a block then passes the divide and emit states: the restoring divider resolves one
// quotient bit per cycle for all channels at once, and the emit state registers the result for the output.
// Reset is synchronous; afterwards a clearing pass zeroes every entry of the column accumulator memory,
// during which req_stall is high (configuration writes still land).
module box_filter_downscaler_top
   import bfd_pkg::*;
#(
   parameter int MAX_OUT_WIDTH = 128,
   parameter int MAX_SCALE     = 32,
   parameter int CHANNELS      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_frame_start,
   input  logic [PIX_W-1:0]      req_chan_r,
   input  logic [PIX_W-1:0]      req_chan_g,
   input  logic [PIX_W-1:0]      req_chan_b,
   input  logic [PIX_W-1:0]      req_chan_a,
   // averaged output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_avg_r,
   output logic [PIX_W-1:0]      rsp_avg_g,
   output logic [PIX_W-1:0]      rsp_avg_b,
   output logic [PIX_W-1:0]      rsp_avg_a,
   output logic [COORD_W-1:0]    rsp_out_col,
   output logic [COORD_W-1:0]    rsp_out_row,
   output logic                  rsp_last_pixel,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(MAX_OUT_WIDTH);
   localparam int COL_W  = $clog2(MAX_OUT_WIDTH + 1);
   localparam int SUB_W  = $clog2(MAX_SCALE);
   localparam int SCL_W  = $clog2(MAX_SCALE + 1);
   localparam int CMP_W  = SCL_W + 1;
   localparam int DIV_W  = $clog2(MAX_SCALE * MAX_SCALE + 1);
   localparam int WORD_W = CHANNELS * SUM_W;

   typedef struct packed {
      logic [ADDR_W-1:0]                addr;
      logic                             first;
      logic                             last;
      logic                             use_alpha;
      logic [COORD_W-1:0]               col;
      logic [COORD_W-1:0]               row;
      logic                             last_pixel;
      logic [DIV_W-1:0]                 divisor;
      logic [CHANNELS-1:0][PIX_W-1:0]   px;
   } pend_type;

   // configuration registers
   logic [SRC_W-1:0] src_width_ff, src_width_in;
   logic [7:0]       out_width_ff, out_width_in;
   logic [7:0]       out_height_ff, out_height_in;
   logic [5:0]       scale_w_ff, scale_w_in;
   logic [5:0]       scale_h_ff, scale_h_in;
   logic             has_alpha_ff, has_alpha_in;

   // position counters
   logic [SRC_CNT_W-1:0] src_col_ff, src_col_in;
   logic [SUB_W-1:0]     sub_col_ff, sub_col_in;
   logic [SUB_W-1:0]     sub_row_ff, sub_row_in;
   logic [COL_W-1:0]     blk_col_ff, blk_col_in;
   logic [ROW_W-1:0]     blk_row_ff, blk_row_in;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   pend_type          pend_ff, pend_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   avg_r_ff, avg_g_ff, avg_b_ff, avg_a_ff;
   logic [COORD_W-1:0] out_col_ff, out_row_ff;
   logic               last_pixel_ff;

   logic              req_accept;
   logic              clr_done;
   logic              pix_active;
   logic              load_rsp;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [WORD_W-1:0] ram_rd_data;
   logic [WORD_W-1:0] new_word;

   logic                           div_start;
   logic                           div_done;
   logic [CHANNELS-1:0][SUM_W-1:0] div_dividend;
   logic [CHANNELS-1:0][SUM_W-1:0] div_quotient;
   logic [3:0][PIX_W-1:0]          avg;

   logic [SCL_W-1:0]     sw, sh;
   logic [COL_W-1:0]     ow;
   logic [ROW_W-1:0]     oh;
   logic [SRC_W-1:0]     srcw;
   logic [SRC_CNT_W-1:0] cur_src_col;
   logic [SUB_W-1:0]     cur_sub_col, cur_sub_row;
   logic [COL_W-1:0]     cur_blk_col;
   logic [ROW_W-1:0]     cur_blk_row;
   logic [3:0][PIX_W-1:0] in_px;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;
   assign clr_done   = (clr_addr_ff == ADDR_W'(MAX_OUT_WIDTH - 1));
   assign in_px      = {req_chan_a, req_chan_b, req_chan_g, req_chan_r};

   // Take configuration beats
   always_comb begin
      src_width_in  = src_width_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      scale_w_in    = scale_w_ff;
      scale_h_in    = scale_h_ff;
      has_alpha_in  = has_alpha_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_in  = csr_data[SRC_W-1:0];
            CSR_OUT_WIDTH:  out_width_in  = csr_data[7:0];
            CSR_OUT_HEIGHT: out_height_in = csr_data[7:0];
            CSR_SCALE_W:    scale_w_in    = csr_data[5:0];
            CSR_SCALE_H:    scale_h_in    = csr_data[5:0];
            CSR_HAS_ALPHA:  has_alpha_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   // Clamp the configuration to what the datapath supports
   always_comb begin
      if (scale_w_ff == '0) begin
         sw = SCL_W'(1);
      end else if (int'(scale_w_ff) > MAX_SCALE) begin
         sw = SCL_W'(MAX_SCALE);
      end else begin
         sw = SCL_W'(scale_w_ff);
      end
      if (scale_h_ff == '0) begin
         sh = SCL_W'(1);
      end else if (int'(scale_h_ff) > MAX_SCALE) begin
         sh = SCL_W'(MAX_SCALE);
      end else begin
         sh = SCL_W'(scale_h_ff);
      end
      if (int'(out_width_ff) > MAX_OUT_WIDTH) begin
         ow = COL_W'(MAX_OUT_WIDTH);
      end else begin
         ow = COL_W'(out_width_ff);
      end
      oh   = (out_height_ff > MAX_OUT_HEIGHT) ? MAX_OUT_HEIGHT : out_height_ff;
      srcw = (src_width_ff == '0 || src_width_ff > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH
                                                                  : src_width_ff;
   end

   // Restart the position on frame start
   always_comb begin
      cur_src_col = req_frame_start ? '0 : src_col_ff;
      cur_sub_col = req_frame_start ? '0 : sub_col_ff;
      cur_sub_row = req_frame_start ? '0 : sub_row_ff;
      cur_blk_col = req_frame_start ? '0 : blk_col_ff;
      cur_blk_row = req_frame_start ? '0 : blk_row_ff;
      pix_active  = (cur_blk_col < ow) && (cur_blk_row < oh);
   end

   // Advance the position counters on each accepted beat
   always_comb begin
      src_col_in = src_col_ff;
      sub_col_in = sub_col_ff;
      sub_row_in = sub_row_ff;
      blk_col_in = blk_col_ff;
      blk_row_in = blk_row_ff;
      if (req_accept) begin
         sub_row_in = cur_sub_row;
         blk_row_in = cur_blk_row;
         if (CMP_W'(cur_sub_col) + CMP_W'(1) >= CMP_W'(sw)) begin
            sub_col_in = '0;
            blk_col_in = (cur_blk_col < ow) ? cur_blk_col + COL_W'(1) : cur_blk_col;
         end else begin
            sub_col_in = cur_sub_col + SUB_W'(1);
            blk_col_in = cur_blk_col;
         end
         if (SRC_W'(cur_src_col) + SRC_W'(1) >= srcw) begin
            src_col_in = '0;
            sub_col_in = '0;
            blk_col_in = '0;
            if (CMP_W'(cur_sub_row) + CMP_W'(1) >= CMP_W'(sh)) begin
               sub_row_in = '0;
               blk_row_in = (cur_blk_row < oh) ? cur_blk_row + ROW_W'(1) : cur_blk_row;
            end else begin
               sub_row_in = cur_sub_row + SUB_W'(1);
            end
         end else begin
            src_col_in = cur_src_col + SRC_CNT_W'(1);
         end
      end
   end

   // Capture the beat for the read-modify-write
   always_comb begin
      pend_in = pend_ff;
      if (req_accept) begin
         pend_in.addr       = cur_blk_col[ADDR_W-1:0];
         pend_in.first      = (cur_sub_col == '0) && (cur_sub_row == '0);
         pend_in.last       = (CMP_W'(cur_sub_col) + CMP_W'(1) == CMP_W'(sw)) &&
                              (CMP_W'(cur_sub_row) + CMP_W'(1) == CMP_W'(sh));
         pend_in.use_alpha  = has_alpha_ff;
         pend_in.col        = COORD_W'(cur_blk_col);
         pend_in.row        = cur_blk_row[COORD_W-1:0];
         pend_in.last_pixel = (cur_blk_col == ow - COL_W'(1)) &&
                              (cur_blk_row == oh - ROW_W'(1));
         pend_in.divisor    = DIV_W'(sw) * DIV_W'(sh);
         for (int c = 0; c < CHANNELS; c++) begin
            pend_in.px[c] = in_px[c];
         end
      end
   end

   // Accumulate or load each channel in use (alpha only with has_alpha); clear it once the block is done
   always_comb begin
      logic [SUM_W-1:0] old_sum;
      logic [SUM_W-1:0] sum;
      old_sum = '0;
      sum     = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         old_sum = ram_rd_data[c*SUM_W +: SUM_W];
         sum     = pend_ff.first ? SUM_W'(pend_ff.px[c])
                                 : old_sum + SUM_W'(pend_ff.px[c]);
         if (c < 3 || pend_ff.use_alpha) begin
            new_word[c*SUM_W +: SUM_W] = pend_ff.last ? '0 : sum;
            div_dividend[c]            = sum;
         end else begin
            new_word[c*SUM_W +: SUM_W] = old_sum;
            div_dividend[c]            = '0;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_accept && pix_active) state_in = ST_READ;
         ST_READ:   state_in = pend_ff.last ? ST_DIVIDE : ST_IDLE;
         ST_DIVIDE: if (div_done) state_in = ST_EMIT;
         ST_EMIT:   if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs per state
   always_comb begin
      req_stall   = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pend_ff.addr;
      ram_wr_data = new_word;
      ram_rd_en   = 1'b0;
      div_start   = 1'b0;
      load_rsp    = 1'b0;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            ram_rd_en = req_valid && pix_active;
         end
         ST_READ: begin
            ram_wr_en = 1'b1;
            div_start = pend_ff.last;
         end
         ST_DIVIDE: ;
         ST_EMIT: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
   end

   // Saturate the quotients to a pixel
   always_comb begin
      avg = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         avg[c] = (div_quotient[c] > SUM_W'(PIX_MAX)) ? PIX_MAX : div_quotient[c][PIX_W-1:0];
      end
   end

   // Hold the result until the output side takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= RST_SRC_WIDTH;
         out_width_ff  <= RST_OUT_WIDTH;
         out_height_ff <= RST_OUT_HEIGHT;
         scale_w_ff    <= RST_SCALE_W;
         scale_h_ff    <= RST_SCALE_H;
         has_alpha_ff  <= RST_HAS_ALPHA;
         src_col_ff    <= '0;
         sub_col_ff    <= '0;
         sub_row_ff    <= '0;
         blk_col_ff    <= '0;
         blk_row_ff    <= '0;
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         src_width_ff  <= src_width_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         scale_w_ff    <= scale_w_in;
         scale_h_ff    <= scale_h_in;
         has_alpha_ff  <= has_alpha_in;
         src_col_ff    <= src_col_in;
         sub_col_ff    <= sub_col_in;
         sub_row_ff    <= sub_row_in;
         blk_col_ff    <= blk_col_in;
         blk_row_ff    <= blk_row_in;
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_ff <= pend_in;
      if (load_rsp) begin
         avg_r_ff      <= avg[0];
         avg_g_ff      <= avg[1];
         avg_b_ff      <= avg[2];
         avg_a_ff      <= avg[3];
         out_col_ff    <= pend_ff.col;
         out_row_ff    <= pend_ff.row;
         last_pixel_ff <= pend_ff.last_pixel;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_avg_r      = avg_r_ff;
   assign rsp_avg_g      = avg_g_ff;
   assign rsp_avg_b      = avg_b_ff;
   assign rsp_avg_a      = avg_a_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_last_pixel = last_pixel_ff;

   bfd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_OUT_WIDTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cur_blk_col[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   bfd_divider #(
      .LANES (CHANNELS),
      .DIV_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (pend_ff.divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // A result only appears after the emit state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result loaded outside emit state");

   // The memory is never read and written in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("memory read overlaps write-back");

   // The read state follows an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(req_valid && !req_stall))
      else $error("read state without an accepted beat");

   // A block-completing beat goes to the divider
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && pend_ff.last) |=> (state_ff == ST_DIVIDE))
      else $error("completed block did not start division");

   // The divider finishes only while the control waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside divide state");

endmodule

[tb/box_filter_downscaler_top_test.sv]
`timescale 1ns / 100ps

module box_filter_downscaler_top_test;
   import bfd_pkg::*;

   localparam int MAX_COLS      = 128;
   localparam int MAX_BLOCK     = 32;
   localparam int NUM_CH        = 4;
   localparam int SUM_ENTRIES   = MAX_COLS * NUM_CH;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PIXELS = 1900;

   // register indexes that decode to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic             fs;
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
      logic [PIX_W-1:0] a;
   } pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0]   r;
      logic [PIX_W-1:0]   g;
      logic [PIX_W-1:0]   b;
      logic [PIX_W-1:0]   a;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } avg_type;

   typedef enum logic [1:0] {ROW_REG, ROW_PIX, ROW_PIX_EXP} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      pixel_type             pix;
      avg_type               exp;
   } step_row_type;

   typedef enum int {
      PH_FULL_SCALE, PH_WIDE, PH_TALL, PH_WIDE_BLOCK, PH_ODD_REGS, PH_PLAIN
   } phase_kind_type;

   localparam int PLAN_ROWS = 39;

   // directed opening: 1x1 blocks with typed results, a 2x2 truncation case,
   // then degenerate and oversized register values
   step_row_type plan [PLAN_ROWS] = '{
      '{ROW_REG, CSR_SCALE_W, 13'd1, '0, '0},
      '{ROW_REG, CSR_SCALE_H, 13'd1, '0, '0},
      '{ROW_REG, CSR_SRC_WIDTH, 13'd2, '0, '0},
      '{ROW_REG, CSR_OUT_WIDTH, 13'd2, '0, '0},
      '{ROW_REG, CSR_OUT_HEIGHT, 13'd2, '0, '0},
      '{ROW_PIX_EXP, '0, '0, {1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        {8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd0, 7'd0, 1'b0}},
      '{ROW_PIX_EXP, '0, '0, {1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
        {8'h00, 8'h00, 8'h00, 8'h00, 7'd1, 7'd0, 1'b0}},
      '{ROW_PIX_EXP, '0, '0, {1'b0, 8'h55, 8'hAA, 8'h0F, 8'hF0},
        {8'h55, 8'hAA, 8'h0F, 8'hF0, 7'd0, 7'd1, 1'b0}},
      '{ROW_PIX_EXP, '0, '0, {1'b0, 8'hAA, 8'h55, 8'hF0, 8'h0F},
        {8'hAA, 8'h55, 8'hF0, 8'h0F, 7'd1, 7'd1, 1'b1}},
      '{ROW_PIX, '0, '0, {1'b0, 8'h01, 8'h02, 8'h03, 8'h04}, '0},
      '{ROW_PIX_EXP, '0, '0, {1'b1, 8'h80, 8'h7F, 8'h01, 8'hFE},
        {8'h80, 8'h7F, 8'h01, 8'hFE, 7'd0, 7'd0, 1'b0}},
      '{ROW_REG, CSR_HAS_ALPHA, 13'd0, '0, '0},
      '{ROW_PIX_EXP, '0, '0, {1'b1, 8'h0A, 8'h14, 8'h1E, 8'h28},
        {8'h0A, 8'h14, 8'h1E, 8'h00, 7'd0, 7'd0, 1'b0}},
      '{ROW_REG, CSR_HAS_ALPHA, 13'd1, '0, '0},
      '{ROW_REG, CSR_SCALE_W, 13'd2, '0, '0},
      '{ROW_REG, CSR_SCALE_H, 13'd2, '0, '0},
      '{ROW_REG, CSR_SRC_WIDTH, 13'd4, '0, '0},
      '{ROW_REG, CSR_OUT_HEIGHT, 13'd1, '0, '0},
      '{ROW_PIX, '0, '0, {1'b1, 8'h01, 8'hFF, 8'h00, 8'hC3}, '0},
      '{ROW_PIX, '0, '0, {1'b0, 8'h02, 8'hFF, 8'h00, 8'h3C}, '0},
      '{ROW_PIX, '0, '0, {1'b0, 8'hFE, 8'h01, 8'hFF, 8'h00}, '0},
      '{ROW_PIX, '0, '0, {1'b0, 8'hFD, 8'h00, 8'hFF, 8'hFF}, '0},
      '{ROW_PIX, '0, '0, {1'b0, 8'h02, 8'hFF, 8'h00, 8'h81}, '0},
      '{ROW_PIX, '0, '0, {1'b0, 8'h02, 8'hFE, 8'h00, 8'h7E}, '0},
      '{ROW_PIX, '0, '0, {1'b0, 8'h03, 8'h00, 8'hFF, 8'h11}, '0},
      '{ROW_PIX, '0, '0, {1'b0, 8'h04, 8'h01, 8'hFF, 8'h22}, '0},
      '{ROW_REG, CSR_SCALE_W, 13'd0, '0, '0},
      '{ROW_REG, CSR_SCALE_H, 13'd63, '0, '0},
      '{ROW_REG, CSR_OUT_WIDTH, 13'd0, '0, '0},
      '{ROW_PIX, '0, '0, {1'b1, 8'h12, 8'h34, 8'h56, 8'h78}, '0},
      '{ROW_REG, CSR_OUT_WIDTH, 13'h1C8, '0, '0},
      '{ROW_REG, CSR_SRC_WIDTH, 13'd0, '0, '0},
      '{ROW_REG, CSR_OUT_HEIGHT, 13'd255, '0, '0},
      '{ROW_PIX, '0, '0, {1'b1, 8'h9A, 8'hBC, 8'hDE, 8'hF1}, '0},
      '{ROW_PIX, '0, '0, {1'b0, 8'h23, 8'h45, 8'h67, 8'h89}, '0},
      '{ROW_REG, CSR_SRC_WIDTH, 13'd8191, '0, '0},
      '{ROW_PIX, '0, '0, {1'b0, 8'hCD, 8'hEF, 8'h10, 8'h32}, '0},
      '{ROW_REG, CSR_SPARE_LO, 13'h1FFF, '0, '0},
      '{ROW_PIX, '0, '0, {1'b1, 8'h76, 8'h54, 8'h32, 8'h10}, '0}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_frame_start = 1'b0;
   logic [PIX_W-1:0]      req_chan_r = '0;
   logic [PIX_W-1:0]      req_chan_g = '0;
   logic [PIX_W-1:0]      req_chan_b = '0;
   logic [PIX_W-1:0]      req_chan_a = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_avg_r;
   logic [PIX_W-1:0]      rsp_avg_g;
   logic [PIX_W-1:0]      rsp_avg_b;
   logic [PIX_W-1:0]      rsp_avg_a;
   logic [COORD_W-1:0]    rsp_out_col;
   logic [COORD_W-1:0]    rsp_out_row;
   logic                  rsp_last_pixel;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the registers
   logic [SRC_W-1:0] cfg_src_width;
   logic [7:0]       cfg_out_width;
   logic [7:0]       cfg_out_height;
   logic [5:0]       cfg_scale_w;
   logic [5:0]       cfg_scale_h;
   logic             cfg_has_alpha;

   // predictor copy of the accumulators and position counters
   logic [SUM_W-1:0] col_sums [SUM_ENTRIES];
   int unsigned      src_col, src_row, sub_col, sub_row, blk_col, blk_row;

   avg_type pending_avgs [$];
   int   mismatch_count = 0;
   int   sent_pixels = 0;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   stall_run = 0;
   int   free_run = 0;

   box_filter_downscaler_top #(
      .MAX_OUT_WIDTH(MAX_COLS),
      .MAX_SCALE    (MAX_BLOCK),
      .CHANNELS     (NUM_CH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_start(req_frame_start),
      .req_chan_r     (req_chan_r),
      .req_chan_g     (req_chan_g),
      .req_chan_b     (req_chan_b),
      .req_chan_a     (req_chan_a),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_avg_r      (rsp_avg_r),
      .rsp_avg_g      (rsp_avg_g),
      .rsp_avg_b      (rsp_avg_b),
      .rsp_avg_a      (rsp_avg_a),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** box_filter_downscaler_top: FAILED **");
         $finish;
      end
   end

   // accumulate one pixel; return 1 when it closes a block, with the averages
   function automatic bit predict_block_avg(input pixel_type p, output avg_type res);
      int unsigned      sw, sh, srcw, ow, oh, nch, base, idx, div, quo, c;
      bit               opens_block, closes_block, got;
      logic [PIX_W-1:0] px [4];
      logic [PIX_W-1:0] avg_v [4];
      got = 1'b0;
      res = '0;
      sw = (cfg_scale_w == 0) ? 1 : ((cfg_scale_w > MAX_BLOCK) ? MAX_BLOCK : cfg_scale_w);
      sh = (cfg_scale_h == 0) ? 1 : ((cfg_scale_h > MAX_BLOCK) ? MAX_BLOCK : cfg_scale_h);
      srcw = (cfg_src_width == 0 || cfg_src_width > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH
                                                                   : cfg_src_width;
      ow = (cfg_out_width > MAX_COLS) ? MAX_COLS : cfg_out_width;
      oh = (cfg_out_height > MAX_OUT_HEIGHT) ? MAX_OUT_HEIGHT : cfg_out_height;
      nch = cfg_has_alpha ? 4 : 3;
      if (p.fs) begin
         src_col = 0; src_row = 0;
         sub_col = 0; sub_row = 0;
         blk_col = 0; blk_row = 0;
      end
      px[0] = p.r; px[1] = p.g; px[2] = p.b; px[3] = p.a;

      if (blk_col < ow && blk_row < oh) begin
         base = blk_col * NUM_CH;
         opens_block = (sub_col == 0 && sub_row == 0);
         closes_block = (sub_col == sw - 1 && sub_row == sh - 1);
         // load on the block's first pixel, add otherwise
         for (c = 0; c < nch; c++) begin
            idx = (base + c) % SUM_ENTRIES;
            col_sums[idx] = opens_block ? SUM_W'(px[c]) : col_sums[idx] + SUM_W'(px[c]);
         end
         if (closes_block) begin
            div = sw * sh;
            for (c = 0; c < 4; c++) begin
               quo = 0;
               if (c < nch) begin
                  idx = (base + c) % SUM_ENTRIES;
                  quo = col_sums[idx] / div;
                  if (quo > PIX_MAX) quo = PIX_MAX;
                  col_sums[idx] = '0;
               end
               avg_v[c] = PIX_W'(quo);
            end
            res.r = avg_v[0];
            res.g = avg_v[1];
            res.b = avg_v[2];
            res.a = avg_v[3];
            res.col = COORD_W'(blk_col);
            res.row = COORD_W'(blk_row);
            res.last = (blk_col == ow - 1 && blk_row == oh - 1);
            got = 1'b1;
         end
      end

      // advance inside the line, then wrap at the end of the source line
      if (sub_col + 1 >= sw) begin
         sub_col = 0;
         if (blk_col < ow) blk_col++;
      end else begin
         sub_col++;
      end
      if (src_col + 1 >= srcw) begin
         src_col = 0;
         sub_col = 0;
         blk_col = 0;
         src_row = (src_row + 1) & 12'hFFF;
         if (sub_row + 1 >= sh) begin
            sub_row = 0;
            if (blk_row < oh) blk_row++;
         end else begin
            sub_row++;
         end
      end else begin
         src_col = (src_col + 1) & 12'hFFF;
      end
      return got;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // drive one pixel beat, with bursts and gaps on the sender side
   task automatic send_pixel(input pixel_type p, input bit typed, input avg_type typed_avg);
      int      gap;
      avg_type predicted;
      @(negedge clock);
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                   : $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_valid = 1'b1;
      req_frame_start = p.fs;
      req_chan_r = p.r;
      req_chan_g = p.g;
      req_chan_b = p.b;
      req_chan_a = p.a;
      do @(posedge clock); while (req_stall);
      if (predict_block_avg(p, predicted) || typed)
         pending_avgs.push_back(typed ? typed_avg : predicted);
   endtask

   // stop sending, wait for every expected average, then let the divider drain
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] data;
      int                    fw;
      case (idx)
         CSR_SRC_WIDTH:                 fw = SRC_W;
         CSR_OUT_WIDTH, CSR_OUT_HEIGHT: fw = 8;
         CSR_SCALE_W, CSR_SCALE_H:      fw = 6;
         CSR_HAS_ALPHA:                 fw = 1;
         default:                       fw = CSR_DATA_W;
      endcase
      data = value[CSR_DATA_W-1:0];
      // now and then set the bits above the register's width
      if (fw < CSR_DATA_W && $urandom_range(0, 7) == 0)
         data = data | (CSR_DATA_W'($urandom) << fw);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SRC_WIDTH:  cfg_src_width = data[SRC_W-1:0];
         CSR_OUT_WIDTH:  cfg_out_width = data[7:0];
         CSR_OUT_HEIGHT: cfg_out_height = data[7:0];
         CSR_SCALE_W:    cfg_scale_w = data[5:0];
         CSR_SCALE_H:    cfg_scale_h = data[5:0];
         CSR_HAS_ALPHA:  cfg_has_alpha = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one register setting followed by one or two frames
   task automatic run_random_phase(input phase_kind_type kind);
      int unsigned sw, sh, ow, oh, src, esw, esh, esrc, extra, rows, n, cap;
      int          f, i, frames;
      bit          alpha;
      pixel_type   p;
      sw = $urandom_range(1, 4);
      sh = $urandom_range(1, 4);
      ow = $urandom_range(1, 8);
      oh = $urandom_range(1, 4);
      alpha = $urandom_range(0, 1);
      extra = $urandom_range(0, 3);
      case (kind)
         PH_FULL_SCALE: begin sw = 32; sh = 32; ow = 1; oh = 1; extra = 0; end
         PH_WIDE:       begin sw = 1; sh = 1; ow = 128; oh = $urandom_range(1, 2); end
         PH_TALL:       begin sw = 1; sh = $urandom_range(1, 2); ow = 1; oh = 128; extra = 0; end
         PH_WIDE_BLOCK: begin sw = 32; sh = $urandom_range(1, 2); ow = $urandom_range(1, 2); oh = 1; end
         default: ;
      endcase
      src = ow * sw + extra;
      // short source line: when it is below ow*sw, the right-hand blocks never close
      if (kind == PH_PLAIN && $urandom_range(0, 5) == 0) src = $urandom_range(1, ow * sw);
      if (kind == PH_ODD_REGS) begin
         case ($urandom_range(0, 4))
            0: ow = 0;
            1: oh = 0;
            2: begin sw = 0; sh = 0; src = ow + extra; end
            3: begin src = 0; sw = 1; sh = 1; end
            default: begin sw = $urandom_range(33, 63); sh = 1; ow = 1; src = $urandom_range(32, 40); end
         endcase
      end
      esw = (sw == 0) ? 1 : ((sw > MAX_BLOCK) ? MAX_BLOCK : sw);
      esh = (sh == 0) ? 1 : ((sh > MAX_BLOCK) ? MAX_BLOCK : sh);
      esrc = (src == 0 || src > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src;

      settle();
      write_reg(CSR_SRC_WIDTH, src);
      write_reg(CSR_OUT_WIDTH, ow);
      write_reg(CSR_OUT_HEIGHT, oh);
      write_reg(CSR_SCALE_W, sw);
      write_reg(CSR_SCALE_H, sh);
      write_reg(CSR_HAS_ALPHA, alpha);
      if ($urandom_range(0, 3) == 0)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);

      cap = (esrc > 512) ? 80 : 1100;
      frames = (kind == PH_FULL_SCALE) ? 1 : $urandom_range(1, 2);
      for (f = 0; f < frames; f++) begin
         rows = oh * esh + $urandom_range(0, 1);
         if (rows == 0) rows = 2;
         n = esrc * rows;
         if (n > cap) n = cap;
         // broken frame: may be cut short before the next frame start
         if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
         for (i = 0; i < n; i++) begin
            p.fs = (i == 0) || ($urandom_range(0, 299) == 0);
            p.r = (kind == PH_FULL_SCALE) ? PIX_MAX : PIX_W'($urandom);
            p.g = PIX_W'($urandom);
            p.b = PIX_W'($urandom);
            p.a = PIX_W'($urandom);
            send_pixel(p, 1'b0, '0);
            sent_pixels++;
         end
      end
   endtask

   // receiver: stall runs between free runs of random length
   always @(negedge clock) begin
      if (stall_run > 0) begin
         rsp_stall = 1'b1;
         stall_run--;
      end else if (free_run > 0) begin
         rsp_stall = 1'b0;
         free_run--;
      end else begin
         stall_run = $urandom_range(0, 6);
         free_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      end
   end

   // compare each accepted result beat against the oldest expectation
   always @(posedge clock) begin : check_results
      avg_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_avgs.size() == 0) begin
            $error("unexpected result at col %0d row %0d", rsp_out_col, rsp_out_row);
            mismatch_count++;
         end else begin
            want = pending_avgs.pop_front();
            check_field("avg_r", want.r, rsp_avg_r);
            check_field("avg_g", want.g, rsp_avg_g);
            check_field("avg_b", want.b, rsp_avg_b);
            check_field("avg_a", want.a, rsp_avg_a);
            check_field("out_col", want.col, rsp_out_col);
            check_field("out_row", want.row, rsp_out_row);
            check_field("last_pixel", want.last, rsp_last_pixel);
         end
      end
   end

   initial begin : stimulus
      int             k, phase, sel;
      phase_kind_type kind;
      cfg_src_width = RST_SRC_WIDTH;
      cfg_out_width = RST_OUT_WIDTH;
      cfg_out_height = RST_OUT_HEIGHT;
      cfg_scale_w = RST_SCALE_W;
      cfg_scale_h = RST_SCALE_H;
      cfg_has_alpha = RST_HAS_ALPHA;
      foreach (col_sums[e]) col_sums[e] = '0;
      src_col = 0; src_row = 0;
      sub_col = 0; sub_row = 0;
      blk_col = 0; blk_row = 0;

      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the directed table
      for (k = 0; k < PLAN_ROWS; k++) begin
         case (plan[k].kind)
            ROW_REG: begin
               settle();
               write_reg(plan[k].idx, plan[k].data);
            end
            ROW_PIX:     send_pixel(plan[k].pix, 1'b0, '0);
            ROW_PIX_EXP: send_pixel(plan[k].pix, 1'b1, plan[k].exp);
            default: ;
         endcase
      end

      // extremes first, then mostly small random settings
      phase = 0;
      while (sent_pixels < RANDOM_PIXELS) begin
         sel = $urandom_range(1, 9);
         if (phase <= PH_ODD_REGS) kind = phase_kind_type'(phase);
         else if (sel >= PH_PLAIN) kind = PH_PLAIN;
         else kind = phase_kind_type'(sel);
         run_random_phase(kind);
         phase++;
      end

      settle();
      if (mismatch_count == 0) begin
         $display("** box_filter_downscaler_top: PASSED **");
      end else begin
         $display("** box_filter_downscaler_top: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/bfd_pkg.sv
rtl/bfd_ram.sv
rtl/bfd_divider.sv
rtl/box_filter_downscaler_top.sv
tb/box_filter_downscaler_top_test.sv
